FILE: hdl/sssp_pkg.sv
// Package for the servo strike sweep PWM unit: widths, reset values, register indexes.
`default_nettype none
package sssp_pkg;

  localparam int WidthW  = 12;
  localparam int DwellW  = 9;
  localparam int PushW   = 10;
  localparam int ActW    = 11;
  localparam int PhaseW  = 5;
  localparam int UsW     = 15;
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 12;

  localparam int FrameMs = 20;

  localparam logic [WidthW-1:0] RestWidthRst   = 12'd1000;
  localparam logic [WidthW-1:0] ActiveWidthRst = 12'd1500;
  localparam logic [DwellW-1:0] DwellRst       = 9'd0;
  localparam logic [PushW-1:0]  PushRst        = 10'd200;

  localparam logic [WidthW-1:0] WidthMax = {WidthW{1'b1}};
  localparam logic [UsW-1:0]    UsMax    = {UsW{1'b1}};

  typedef enum logic [CfgIdxW-1:0] {
    CFG_REST_WIDTH   = 3'd0,
    CFG_ACTIVE_WIDTH = 3'd1,
    CFG_DWELL_TIME   = 3'd2,
    CFG_PUSH_TIME    = 3'd3,
    CFG_SMOOTH_MODE  = 3'd4,
    CFG_WAIT_MODE    = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic              pulse_out;
    logic [WidthW-1:0] pulse_width;
    logic              pushing;
    logic              driving;
  } result_t;

endpackage
`default_nettype wire

FILE: hdl/servo_strike_sweep_pwm_unit.sv
// Servo strike sweep PWM channel: request latch, width ramp, 20 ms servo framing.
//
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  in      | in_valid_i, in_stall_o, ms_tick_i,           | into block
//          | note_request_i                               |
//  out     | out_valid_o, out_stall_i, pulse_out_o,       | out of block
//          | pulse_width_o, pushing_o, driving_o          |
//  cfg     | cfg_we_i, cfg_index_i, cfg_data_i            | into block
//
// One tick per cycle while the input is not stalled: the state update is one pass
// of logic from the state registers to the result register, which is the main register,
// or the skid register while a result waits. The ramp step span/divisor comes from a
// radix-2 serial divider that loads its operands, then runs 12 quotient steps, after
// reset and after every register write. The input stalls during the write cycle, while
// the divider runs and while the skid register holds a transfer taken while a result waits.
`default_nettype none
module servo_strike_sweep_pwm_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         ms_tick_i,
  input  wire logic                         note_request_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              pulse_out_o,
  output logic [sssp_pkg::WidthW-1:0]       pulse_width_o,
  output logic                              pushing_o,
  output logic                              driving_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [sssp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [sssp_pkg::CfgW-1:0]    cfg_data_i
);
  import sssp_pkg::*;

  localparam int DivCntW = $clog2(WidthW + 1);
  localparam logic [DivCntW-1:0] DivSteps = DivCntW'(WidthW);

  // configuration registers
  logic [WidthW-1:0] rest_q, active_q;
  logic [DwellW-1:0] dwell_q;
  logic [PushW-1:0]  push_q;
  logic              smooth_q, wait_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rest_q   <= RestWidthRst;
      active_q <= ActiveWidthRst;
      dwell_q  <= DwellRst;
      push_q   <= PushRst;
      smooth_q <= 1'b1;
      wait_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_REST_WIDTH:   rest_q   <= cfg_data_i[WidthW-1:0];
        CFG_ACTIVE_WIDTH: active_q <= cfg_data_i[WidthW-1:0];
        CFG_DWELL_TIME:   dwell_q  <= cfg_data_i[DwellW-1:0];
        CFG_PUSH_TIME:    push_q   <= cfg_data_i[PushW-1:0];
        CFG_SMOOTH_MODE:  smooth_q <= cfg_data_i[0];
        CFG_WAIT_MODE:    wait_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ramp step divider operands
  logic              dir_down;
  logic [WidthW-1:0] span;
  logic [DwellW-1:0] half_push;
  logic [DwellW-1:0] divisor;

  assign dir_down  = rest_q > active_q;
  assign span      = dir_down ? rest_q - active_q : active_q - rest_q;
  assign half_push = push_q[PushW-1:1];
  // divisor forced to at least one
  assign divisor   = (dwell_q >= half_push) ? DwellW'(1) : half_push - dwell_q;

  // serial restoring divider; quotient shifts into the numerator register
  logic               start_q;
  logic               busy_q;
  logic [DivCntW-1:0] cnt_q;
  logic [WidthW-1:0]  num_q, step_q;
  logic [DwellW-1:0]  rem_q, dv_q;
  logic [DwellW:0]    rem_sh;
  logic               rem_ge;

  assign rem_sh = {rem_q, num_q[WidthW-1]};
  assign rem_ge = rem_sh >= {1'b0, dv_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b1;
      busy_q  <= 1'b0;
      cnt_q   <= '0;
    end else if (cfg_we_i) begin
      start_q <= 1'b1;
      busy_q  <= 1'b0;
    end else if (start_q) begin
      start_q <= 1'b0;
      busy_q  <= 1'b1;
      cnt_q   <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + DivCntW'(1);
      if (cnt_q == DivSteps - DivCntW'(1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_q) begin
      num_q <= span;
      rem_q <= '0;
      dv_q  <= divisor;
    end else if (busy_q) begin
      num_q <= {num_q[WidthW-2:0], rem_ge};
      rem_q <= rem_ge ? DwellW'(rem_sh - {1'b0, dv_q}) : rem_sh[DwellW-1:0];
      if (cnt_q == DivSteps - DivCntW'(1)) step_q <= {num_q[WidthW-2:0], rem_ge};
    end
  end

  logic div_busy;
  assign div_busy = start_q | busy_q | cfg_we_i;

  // output buffer
  logic    out_valid_q, skid_valid_q;
  result_t main_q, skid_q;
  logic    in_acc, out_pop;

  assign in_stall_o = div_busy | skid_valid_q;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign out_pop    = out_valid_q & ~out_stall_i;

  // channel state
  logic              req_q, fwd_q, pin_q;
  logic [WidthW-1:0] wnow_q;
  logic [ActW-1:0]   act_q;
  logic [PhaseW-1:0] phase_q;
  logic [UsW-1:0]    us_q;

  logic              req_d, fwd_d, pin_d;
  logic [WidthW-1:0] wnow_d;
  logic [ActW-1:0]   act_d;
  logic [PhaseW-1:0] phase_d;
  logic [UsW-1:0]    us_d;
  logic              drive_d;

  logic              latch, fwd1;
  logic [ActW-1:0]   act1;
  logic [ActW:0]     act1_x2;
  logic [ActW-1:0]   push_x2;
  logic [WidthW:0]   w_plus;
  logic [WidthW-1:0] w_add, w_sub;
  logic [PhaseW-1:0] phase_inc;
  logic              frame_start;

  always_comb begin
    latch   = req_q | note_request_i;
    req_d   = latch;
    fwd1    = fwd_q;
    act1    = act_q;
    if (latch) begin
      if (!wait_q || (act_q >= ActW'(push_q))) begin
        fwd1 = 1'b1;
        act1 = '0;
      end
    end
    act1_x2 = {act1, 1'b0};
    push_x2 = {push_q, 1'b0};
    w_plus  = {1'b0, wnow_q} + {1'b0, step_q};
    w_add   = w_plus[WidthW] ? WidthMax : w_plus[WidthW-1:0];
    w_sub   = (step_q > wnow_q) ? '0 : wnow_q - step_q;

    fwd_d   = fwd_q;
    wnow_d  = wnow_q;
    act_d   = act_q;
    phase_d = phase_q;
    frame_start = 1'b0;
    phase_inc = phase_q + PhaseW'(1);

    if (ms_tick_i) begin
      req_d = 1'b0;
      fwd_d = fwd1;
      if (smooth_q) begin
        if (dir_down) begin
          if (fwd1) begin
            if (wnow_q > active_q) wnow_d = w_sub;
            else if ((ActW + 1)'(push_q) < act1_x2) fwd_d = 1'b0;
          end else if (wnow_q < rest_q) begin
            wnow_d = w_add;
          end
        end else begin
          if (fwd1) begin
            if (wnow_q < active_q) wnow_d = w_add;
            else if ((ActW + 1)'(push_q) < act1_x2) fwd_d = 1'b0;
          end else if (wnow_q > rest_q) begin
            wnow_d = w_sub;
          end
        end
      end else begin
        if ((act1_x2 < (ActW + 1)'(push_q)) && fwd1) begin
          wnow_d = active_q;
        end else begin
          wnow_d = rest_q;
          fwd_d  = 1'b0;
        end
      end
      act_d = (act1 < push_x2) ? act1 + ActW'(1) : act1;
      phase_d = (phase_inc >= PhaseW'(FrameMs)) ? '0 : phase_inc;
      frame_start = (phase_d == '0);
    end

    us_d    = (us_q < UsMax) ? us_q + UsW'(1) : us_q;
    drive_d = act_d < (ActW'(push_q) + ActW'(half_push));
    pin_d   = pin_q;
    if (drive_d) begin
      if (frame_start) begin
        us_d  = '0;
        pin_d = 1'b1;
      end else if (UsW'(wnow_d) < us_d) begin
        pin_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q   <= 1'b0;
      fwd_q   <= 1'b0;
      wnow_q  <= RestWidthRst;
      act_q   <= '0;
      phase_q <= '0;
      us_q    <= '0;
      pin_q   <= 1'b0;
    end else if (in_acc) begin
      req_q   <= req_d;
      fwd_q   <= fwd_d;
      wnow_q  <= wnow_d;
      act_q   <= act_d;
      phase_q <= phase_d;
      us_q    <= us_d;
      pin_q   <= pin_d;
    end
  end

  result_t res_d;
  assign res_d = '{pulse_out: pin_d, pulse_width: wnow_d, pushing: fwd_d, driving: drive_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_pop) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_pop) begin
      if (skid_valid_q) main_q <= skid_q;
      else if (in_acc)  main_q <= res_d;
    end else if (in_acc) begin
      skid_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pulse_out_o   = main_q.pulse_out;
  assign pulse_width_o = main_q.pulse_width;
  assign pushing_o     = main_q.pushing;
  assign driving_o     = main_q.driving;

  // skid entry only exists behind a held main entry
  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q) else $error("skid valid without main valid");

  // no tick is taken while the ramp step is being recomputed
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_q || busy_q) |-> !in_acc) else $error("tick accepted during step divide");

  // a push only starts on an accepted millisecond tick
  a_push_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(fwd_q) |-> $past(in_acc && ms_tick_i)) else $error("push started off a tick");

  // channel state only moves on an accepted tick
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |=> $stable(wnow_q) && $stable(act_q))
    else $error("channel state moved without a tick");

endmodule
`default_nettype wire

FILE: sim/servo_tick_checker.sv
// Checker for the servo strike sweep unit: predicts every tick result and compares it.
`default_nettype none
module servo_tick_checker
  import sssp_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_stall_i,
  input  wire logic               ms_tick_i,
  input  wire logic               note_request_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_stall_i,
  input  wire logic               pulse_out_i,
  input  wire logic [WidthW-1:0]  pulse_width_i,
  input  wire logic               pushing_i,
  input  wire logic               driving_i,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CfgW-1:0]    cfg_data_i,
  output int                      fail_count_o,
  output int                      pending_o,
  output int                      checked_o
);

  // register copies
  logic [WidthW-1:0] rest_w;
  logic [WidthW-1:0] active_w;
  logic [DwellW-1:0] dwell;
  logic [PushW-1:0]  push;
  logic              smooth;
  logic              wait_on;

  // channel state
  logic              req_latched;
  logic              forward;
  logic [WidthW-1:0] width_now;
  logic [ActW-1:0]   active_ms;
  logic [PhaseW-1:0] phase;
  logic [UsW-1:0]    elapsed;
  logic              pin;

  result_t due_pulses_q[$];
  int      fails;
  int      checked;

  function automatic logic [WidthW-1:0] width_plus(logic [WidthW-1:0] w, int d);
    int s;
    s = int'(w) + d;
    return (s > int'(WidthMax)) ? WidthMax : WidthW'(s);
  endfunction

  function automatic logic [WidthW-1:0] width_minus(logic [WidthW-1:0] w, int d);
    return (d > int'(w)) ? '0 : WidthW'(int'(w) - d);
  endfunction

  // Millisecond step: request, width move, active time count.
  task automatic step_millisecond();
    int am;
    int pt;
    int div;
    int span;
    int stp;
    am = int'(active_ms);
    pt = int'(push);
    if (req_latched) begin
      req_latched = 1'b0;
      if (!wait_on || am >= pt) begin
        forward   = 1'b1;
        active_ms = '0;
        am        = 0;
      end
    end
    if (smooth) begin
      div = int'(push >> 1) - int'(dwell);
      if (div < 1) div = 1;
      span = (rest_w > active_w) ? int'(rest_w) - int'(active_w)
                                 : int'(active_w) - int'(rest_w);
      stp = span / div;
      if (rest_w > active_w) begin
        if (forward) begin
          if (width_now > active_w) width_now = width_minus(width_now, stp);
          else if (pt < am * 2) forward = 1'b0;
        end else if (width_now < rest_w) begin
          width_now = width_plus(width_now, stp);
        end
      end else begin
        if (forward) begin
          if (width_now < active_w) width_now = width_plus(width_now, stp);
          else if (pt < am * 2) forward = 1'b0;
        end else if (width_now > rest_w) begin
          width_now = width_minus(width_now, stp);
        end
      end
    end else if (am * 2 < pt && forward) begin
      width_now = active_w;
    end else begin
      width_now = rest_w;
      forward   = 1'b0;
    end
    if (am < pt * 2) active_ms = active_ms + ActW'(1);
  endtask

  // One microsecond tick of the channel.
  task automatic servo_tick(input logic ms, input logic req, output result_t r);
    logic fstart;
    logic drv;
    fstart = 1'b0;
    if (req) req_latched = 1'b1;
    if (ms) begin
      step_millisecond();
      phase  = (int'(phase) + 1 >= FrameMs) ? '0 : phase + PhaseW'(1);
      fstart = (phase == '0);
    end
    if (elapsed < UsMax) elapsed = elapsed + UsW'(1);
    drv = int'(active_ms) < int'(push) + int'(push >> 1);
    if (drv) begin
      if (fstart) begin
        elapsed = '0;
        pin     = 1'b1;
      end else if (UsW'(width_now) < elapsed) begin
        pin = 1'b0;
      end
    end
    r.pulse_out   = pin;
    r.pulse_width = width_now;
    r.pushing     = forward;
    r.driving     = drv;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t want;
    if (!rst_ni) begin
      rest_w      = RestWidthRst;
      active_w    = ActiveWidthRst;
      dwell       = DwellRst;
      push        = PushRst;
      smooth      = 1'b1;
      wait_on     = 1'b0;
      req_latched = 1'b0;
      forward     = 1'b0;
      width_now   = RestWidthRst;
      active_ms   = '0;
      phase       = '0;
      elapsed     = '0;
      pin         = 1'b0;
      fails       = 0;
      checked     = 0;
      due_pulses_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_REST_WIDTH:   rest_w   = cfg_data_i[WidthW-1:0];
          CFG_ACTIVE_WIDTH: active_w = cfg_data_i[WidthW-1:0];
          CFG_DWELL_TIME:   dwell    = cfg_data_i[DwellW-1:0];
          CFG_PUSH_TIME:    push     = cfg_data_i[PushW-1:0];
          CFG_SMOOTH_MODE:  smooth   = cfg_data_i[0];
          CFG_WAIT_MODE:    wait_on  = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        servo_tick(ms_tick_i, note_request_i, want);
        due_pulses_q.push_back(want);
      end
      if (out_valid_i && !out_stall_i) begin
        if (due_pulses_q.size() == 0) begin
          $error("result transfer with no tick outstanding");
          fails++;
        end else begin
          want = due_pulses_q.pop_front();
          checked++;
          if (pulse_out_i !== want.pulse_out) begin
            $error("pulse_out: expected %0d, got %0d", want.pulse_out, pulse_out_i);
            fails++;
          end
          if (pulse_width_i !== want.pulse_width) begin
            $error("pulse_width: expected %0d, got %0d", want.pulse_width, pulse_width_i);
            fails++;
          end
          if (pushing_i !== want.pushing) begin
            $error("pushing: expected %0d, got %0d", want.pushing, pushing_i);
            fails++;
          end
          if (driving_i !== want.driving) begin
            $error("driving: expected %0d, got %0d", want.driving, driving_i);
            fails++;
          end
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= due_pulses_q.size();
    checked_o    <= checked;
  end

endmodule
`default_nettype wire

FILE: sim/testbench.sv
// Testbench top: feeds ticks and register settings to the servo strike unit, gives the verdict.
`default_nettype none
module testbench;
  import sssp_pkg::*;

  localparam int LongHold  = 60;      // sink hold-off, long enough to back up the block
  localparam int IdleTicks = 24;      // undriven stretch: the pin holds
  localparam int Limit     = 300000;
  localparam logic [CfgIdxW-1:0] CfgSpare = 3'd7;  // no register behind this index

  logic clk;
  logic rst_n = 1'b0;

  logic              in_valid  = 1'b0;
  logic              ms_tick   = 1'b0;
  logic              note_req  = 1'b0;
  logic              out_stall = 1'b0;
  logic              cfg_we    = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0]    cfg_data  = '0;

  wire logic              in_stall;
  wire logic              out_valid;
  wire logic              pulse_out;
  wire logic [WidthW-1:0] pulse_width;
  wire logic              pushing;
  wire logic              driving;

  // idling controls; sink_idle and hold_go are read by the sink process
  logic src_idle  = 1'b0;
  logic sink_idle = 1'b0;
  logic hold_go   = 1'b0;

  int fails;
  int pending;
  int checked;
  int ticks_sent   = 0;
  int settings_run = 1;  // reset values count as the first setting
  int cycles       = 0;

  servo_strike_sweep_pwm_unit uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .ms_tick_i      (ms_tick),
    .note_request_i (note_req),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .pulse_out_o    (pulse_out),
    .pulse_width_o  (pulse_width),
    .pushing_o      (pushing),
    .driving_o      (driving),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  servo_tick_checker chk (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .ms_tick_i      (ms_tick),
    .note_request_i (note_req),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .pulse_out_i    (pulse_out),
    .pulse_width_i  (pulse_width),
    .pushing_i      (pushing),
    .driving_i      (driving),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .fail_count_o   (fails),
    .pending_o      (pending),
    .checked_o      (checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > Limit) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Result sink: a random wait per transfer while sink_idle is set, plus one long hold-off on request.
  initial begin : sink
    int   wait_left;
    int   hold_left;
    logic hold_seen;
    wait_left = 0;
    hold_left = 0;
    hold_seen = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) wait_left = sink_idle ? $urandom_range(0, 10) : 0;
      if (hold_go != hold_seen) begin
        hold_seen = hold_go;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (wait_left > 0) begin
        wait_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // One tick transfer; valid stays high across back-to-back items.
  task automatic send_tick(input logic ms, input logic req);
    int gap;
    gap = src_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    ms_tick  <= ms;
    note_req <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ticks_sent++;
  endtask

  // Drop valid and wait until every tick has its result back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Write all registers; unused upper data bits carry junk the block must mask.
  task automatic load_setting(input logic [WidthW-1:0] rw, input logic [WidthW-1:0] aw,
                              input logic [DwellW-1:0] dw, input logic [PushW-1:0] pt,
                              input logic sm, input logic wm);
    write_reg(CFG_REST_WIDTH, rw);
    write_reg(CFG_ACTIVE_WIDTH, aw);
    write_reg(CFG_DWELL_TIME, {3'($urandom), dw});
    write_reg(CFG_PUSH_TIME, {2'($urandom), pt});
    write_reg(CFG_SMOOTH_MODE, {11'($urandom), sm});
    write_reg(CFG_WAIT_MODE, {11'($urandom), wm});
    write_reg(CfgSpare, CfgW'($urandom));
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  // Mostly small widths and push times so frames close and strikes finish quickly.
  task automatic random_setting();
    logic [WidthW-1:0] rw;
    logic [WidthW-1:0] aw;
    logic [DwellW-1:0] dw;
    logic [PushW-1:0]  pt;
    int                pick;
    rw = ($urandom_range(0, 3) != 0) ? WidthW'($urandom_range(0, 80)) : WidthW'($urandom);
    aw = ($urandom_range(0, 3) != 0) ? WidthW'($urandom_range(0, 80)) : WidthW'($urandom);
    pick = $urandom_range(0, 19);
    if (pick < 14) pt = PushW'($urandom_range(0, 40));
    else if (pick < 18) pt = PushW'($urandom);
    else if (pick == 18) pt = '1;
    else pt = PushW'(1);
    dw = ($urandom_range(0, 2) != 0) ? DwellW'($urandom_range(0, pt / 2)) : DwellW'($urandom);
    load_setting(rw, aw, dw, pt, 1'($urandom), 1'($urandom));
  endtask

  task automatic random_ticks(input int n, input int ms_pct, input int req_pct);
    repeat (n) send_tick($urandom_range(0, 99) < ms_pct, $urandom_range(0, 99) < req_pct);
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset setting: plain tick, latched request, millisecond start, request on a ms tick
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b0);
    drain();

    // ramp up with one full-span step: width clips at the top
    load_setting(12'd100, 12'd4095, 9'd0, 10'd2, 1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    drain();

    // active below rest, dwell past half push: divisor clamps, width clips at zero
    load_setting(12'd4000, 12'd0, 9'd511, 10'd10, 1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b0);
    drain();

    // step mode with wait rule and a one-millisecond push
    load_setting(12'd0, 12'd4095, 9'd0, 10'd1, 1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    drain();

    // zero push: never drives, pin holds
    load_setting(12'd20, 12'd60, 9'd0, 10'd0, 1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    drain();

    // undriven stretch: microsecond count runs on while the pin holds
    load_setting(RestWidthRst, ActiveWidthRst, DwellRst, 10'd0, 1'b1, 1'b0);
    repeat (IdleTicks) send_tick($urandom_range(0, 3) == 0, 1'b0);
    drain();

    // drive again after the idle stretch with tiny widths
    load_setting(12'd5, 12'd40, 9'd0, 10'd6, 1'b1, 1'b0);
    src_idle = 1'b1;
    sink_idle <= 1'b1;
    random_ticks(40, 40, 10);
    drain();

    for (int p = 0; p < 9; p++) begin
      random_setting();
      src_idle = ($urandom_range(0, 3) != 0);
      if (p == 4) begin
        // back-pressure: sink stops for a while, source keeps offering
        src_idle = 1'b0;
        sink_idle <= 1'b0;
        hold_go   <= ~hold_go;
      end else begin
        sink_idle <= ($urandom_range(0, 3) != 0);
      end
      random_ticks(35, $urandom_range(15, 70), $urandom_range(3, 20));
      drain();
    end

    // widest push with full-span widths
    load_setting(12'd0, 12'd4095, 9'd0, 10'h3FF, 1'b1, 1'b1);
    src_idle = 1'b1;
    sink_idle <= 1'b1;
    random_ticks(40, 60, 10);
    drain();
    repeat (16) @(posedge clk);

    $display("run covered %0d ticks over %0d register settings, %0d results compared",
             ticks_sent, settings_run, checked);
    if (fails == 0 && pending == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
